// ----- rtl/npcs_pkg.sv -----
package npcs_pkg;

   // Default palette size of the block.
   localparam int PAL_ENTRIES_DEFAULT = 256;

   // Field widths fixed by the word formats.
   localparam int INDEX_W = 8;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 15;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int DIST_W  = 18;
   localparam int PACK_W  = 32;
   localparam int RGB_W   = 3 * CHAN_W;

   // Largest distance a query can report: three channels of 252 squared.
   localparam logic [DIST_W-1:0] DIST_MAX = 18'd190512;

   // Operation codes carried in the func field.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Alpha values of the packed word.
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

   // Input word.
   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] entry_index;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [COLOR_W-1:0] color15;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [PACK_W-1:0]  packed_word;
      logic [INDEX_W-1:0] nearest_index;
      logic [DIST_W-1:0]  best_distance;
   } rsp_word_type;

   // Expands a 5-bit channel to 8 bits as (c << 3) + 4.
   function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] c);
      return {c, 3'b100};
   endfunction

endpackage

// ----- rtl/npcs_if.sv -----
// Input channel: one request word per handshake.
interface npcs_req_if import npcs_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// Result channel: one response word per handshake.
interface npcs_rsp_if import npcs_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/npcs_ram.sv -----
// Single-port synchronous RAM with a registered read.
module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One access per cycle: write when enabled, always read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/nearest_palette_color_search.sv -----
// Load word: the response is registered from ST_DONE once the output slot is free, and the next
// word is taken back in ST_IDLE. Query word: no new word is taken until the scan ends, as the
// single palette RAM port is read once per entry, each read feeding the squares and running minimum.
// A finished response waits in the output register while the next word is accepted.
// Reset (synchronous, active high) clears the control state; palette entries are
// undefined until loaded.
module nearest_palette_color_search import npcs_pkg::*; #(
   parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   npcs_req_if.sink   req_bus,
   npcs_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(PALETTE_ENTRIES - 1);
   localparam logic [INDEX_W:0]   ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);
   localparam logic [INDEX_W-1:0] CLEAR_IDX   = INDEX_W'(PALETTE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Control registers.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_done_ff, issue_done_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             sq_vld_ff, sq_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  sq_idx_ff, sq_idx_in;
   logic [SQ_W-1:0]   sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]   sq_g_ff, sq_g_in;
   logic [SQ_W-1:0]   sq_b_ff, sq_b_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic              query_ff, query_in;
   logic [CHAN_W-1:0] qr_ff, qr_in;
   logic [CHAN_W-1:0] qg_ff, qg_in;
   logic [CHAN_W-1:0] qb_ff, qb_in;
   logic [PACK_W-1:0] pack_ff, pack_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   // Memory port.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_addr;
   logic [RGB_W-1:0] ram_wr_data;
   logic [RGB_W-1:0] ram_rd_data;

   // Datapath helpers.
   logic              req_take;
   logic              slot_free;
   logic [CHAN_W-1:0] ent_r, ent_g, ent_b;
   logic [CHAN_W-1:0] dr, dg, db;
   logic [DIST_W-1:0] dist_sum;
   logic              take_best;
   logic [CHAN_W-1:0] alpha;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign req_take        = req_bus.valid && req_bus.ready;
   assign slot_free       = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_word_ff;

   // Writes on an in-range load; reads the request index while idle, else the scan address.
   assign ram_wr_en   = req_take && (req_bus.payload.func == FUNC_LOAD)
                        && ({1'b0, req_bus.payload.entry_index} < ENTRY_LIMIT);
   assign ram_addr    = (state_ff == ST_IDLE) ? req_bus.payload.entry_index[IDX_W-1:0]
                                              : addr_ff;
   assign ram_wr_data = {req_bus.payload.blue, req_bus.payload.green, req_bus.payload.red};

   npcs_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // Absolute channel differences of the entry just read.
   always_comb begin
      ent_r = ram_rd_data[CHAN_W-1:0];
      ent_g = ram_rd_data[2*CHAN_W-1:CHAN_W];
      ent_b = ram_rd_data[3*CHAN_W-1:2*CHAN_W];
      dr = (qr_ff > ent_r) ? (qr_ff - ent_r) : (ent_r - qr_ff);
      dg = (qg_ff > ent_g) ? (qg_ff - ent_g) : (ent_g - qg_ff);
      db = (qb_ff > ent_b) ? (qb_ff - ent_b) : (ent_b - qb_ff);
   end

   // Sum of the registered squares and the running-minimum decision.
   assign dist_sum  = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
   assign take_best = sq_vld_ff && ((sq_idx_ff == '0) || (dist_sum < best_dist_ff));

   // The last entry of the palette is transparent.
   assign alpha = (req_bus.payload.entry_index == CLEAR_IDX) ? ALPHA_CLEAR : ALPHA_OPAQUE;

   // Next-state logic for the sequencer and the scan pipeline.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = (state_ff == ST_SCAN) && !issue_done_ff;
      rd_idx_in     = addr_ff;
      sq_vld_in     = rd_vld_ff;
      sq_idx_in     = rd_idx_ff;
      sq_r_in       = SQ_W'(dr) * SQ_W'(dr);
      sq_g_in       = SQ_W'(dg) * SQ_W'(dg);
      sq_b_in       = SQ_W'(db) * SQ_W'(db);
      best_idx_in   = take_best ? sq_idx_ff : best_idx_ff;
      best_dist_in  = take_best ? dist_sum : best_dist_ff;
      query_in      = query_ff;
      qr_in         = qr_ff;
      qg_in         = qg_ff;
      qb_in         = qb_ff;
      pack_in       = pack_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_word_in   = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_bus.payload.func == FUNC_LOAD) begin
                  query_in = 1'b0;
                  pack_in  = {alpha, req_bus.payload.blue, req_bus.payload.green,
                              req_bus.payload.red};
                  state_in = ST_DONE;
               end else begin
                  query_in      = 1'b1;
                  qr_in         = expand5(req_bus.payload.color15[4:0]);
                  qg_in         = expand5(req_bus.payload.color15[9:5]);
                  qb_in         = expand5(req_bus.payload.color15[14:10]);
                  addr_in       = '0;
                  issue_done_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               addr_in = addr_ff + IDX_W'(1);
               if (addr_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            if (sq_vld_ff && (sq_idx_ff == LAST_IDX)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (query_ff) begin
                  rsp_word_in.packed_word   = '0;
                  rsp_word_in.nearest_index = INDEX_W'(best_idx_ff);
                  rsp_word_in.best_distance = best_dist_ff;
               end else begin
                  rsp_word_in.packed_word   = pack_ff;
                  rsp_word_in.nearest_index = '0;
                  rsp_word_in.best_distance = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         issue_done_ff <= 1'b1;
         rd_vld_ff     <= 1'b0;
         sq_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         sq_vld_ff     <= sq_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      sq_idx_ff    <= sq_idx_in;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      query_ff     <= query_in;
      qr_ff        <= qr_in;
      qg_ff        <= qg_in;
      qb_ff        <= qb_in;
      pack_ff      <= pack_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule

// ----- rtl/npcs_checker.sv -----
// Port-level checks of the palette search block.
module npcs_checker import npcs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // A stalled response word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // A stalled response word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("response word changed while stalled");

   // An accepted word drops ready, so no two words are accepted back to back.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted in back-to-back cycles");

   // A response carries either a packed entry or a search result, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.packed_word != '0)
      |-> (rsp_word.nearest_index == '0) && (rsp_word.best_distance == '0))
      else $error("load and query fields mixed in one response");

   // The reported distance never exceeds the largest possible one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.best_distance <= DIST_MAX))
      else $error("distance beyond the channel range");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_word  (rsp_bus.payload)
);
